// ===== hdl/ats_pkg.sv =====
package ats_pkg;

    // burst and bus sizing
    localparam int MAX_RES         = 6;
    localparam int MAX_LET         = 4;
    localparam int CNT_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;

    // characters with a role of their own
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_COLON   = ":";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_X       = "x";
    localparam logic [7:0] CH_UNDER   = "_";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_F = "F";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LF      = 8'h0A;

    typedef enum logic [3:0] {
        TOK_NEWLINE = 4'd0,
        TOK_COLON   = 4'd1,
        TOK_DATA    = 4'd2,
        TOK_CODE    = 4'd3,
        TOK_DOT     = 4'd4,
        TOK_WRITE   = 4'd5,
        TOK_READ    = 4'd6,
        TOK_RET     = 4'd7,
        TOK_JMP     = 4'd8,
        TOK_CALL    = 4'd9,
        TOK_IDENT   = 4'd10,
        TOK_DEC     = 4'd11,
        TOK_HEX     = 4'd12,
        TOK_ERROR   = 4'd13
    } tok_t;

    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_COMMENT = 8'b0000_0010,
        MODE_IDENT   = 8'b0000_0100,
        MODE_DEC     = 8'b0000_1000,
        MODE_HEX     = 8'b0001_0000,
        MODE_ZERO    = 8'b0010_0000,
        MODE_HALT    = 8'b0100_0000,
        MODE_PFX     = 8'b1000_0000
    } mode_t;

    // keyword prefixes seen so far
    typedef enum logic [4:0] {
        P_DOT     = 5'd0,
        P_DOT_D   = 5'd1,
        P_DOT_DA  = 5'd2,
        P_DOT_DAT = 5'd3,
        P_DOT_C   = 5'd4,
        P_DOT_CO  = 5'd5,
        P_DOT_COD = 5'd6,
        P_W       = 5'd7,
        P_WR      = 5'd8,
        P_WRI     = 5'd9,
        P_WRIT    = 5'd10,
        P_R       = 5'd11,
        P_RE      = 5'd12,
        P_REA     = 5'd13,
        P_J       = 5'd14,
        P_JM      = 5'd15,
        P_C       = 5'd16,
        P_CA      = 5'd17,
        P_CAL     = 5'd18
    } pfx_t;

    typedef enum logic [1:0] {
        EXT_NONE = 2'd0,
        EXT_PFX  = 2'd1,
        EXT_KW   = 2'd2
    } ext_kind_t;

    typedef struct packed {
        ext_kind_t kind;
        tok_t      tok;
        pfx_t      pfx;
    } ext_t;

    // one result word, token_type in the low bits
    typedef struct packed {
        logic       token_end;
        logic       has_char;
        logic [7:0] content_char;
        tok_t       token_type;
    } res_t;

    localparam int RES_W = $bits(res_t);

    // all results caused by one input word
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        res_t [MAX_RES-1:0] words;
    } burst_t;

    typedef struct packed {
        logic  valid;
        res_t  word;
        mode_t mode;
        pfx_t  pfx;
    } step_t;

    function automatic logic is_alpha(logic [7:0] x);
        return (x >= CH_LOWER_A && x <= CH_LOWER_Z) || (x >= CH_UPPER_A && x <= CH_UPPER_Z)
            || x == CH_UNDER;
    endfunction

    function automatic logic is_digit(logic [7:0] x);
        return x >= CH_ZERO && x <= CH_NINE;
    endfunction

    function automatic logic is_numch(logic [7:0] x);
        return is_digit(x) || (x >= CH_UPPER_A && x <= CH_UPPER_F);
    endfunction

    function automatic res_t mk_char(tok_t t, logic [7:0] c);
        return '{token_end: 1'b0, has_char: 1'b1, content_char: c, token_type: t};
    endfunction

    function automatic res_t mk_end(tok_t t);
        return '{token_end: 1'b1, has_char: 1'b0, content_char: 8'h00, token_type: t};
    endfunction

    function automatic res_t mk_err(logic [7:0] c);
        return '{token_end: 1'b1, has_char: 1'b1, content_char: c, token_type: TOK_ERROR};
    endfunction

    function automatic ext_t mk_pfx(pfx_t p);
        return '{kind: EXT_PFX, tok: TOK_NEWLINE, pfx: p};
    endfunction

    function automatic ext_t mk_kw(tok_t t);
        return '{kind: EXT_KW, tok: t, pfx: P_DOT};
    endfunction

    // token type of a running identifier or number
    function automatic tok_t run_type(mode_t m);
        tok_t t;
        unique case (m)
            MODE_IDENT: t = TOK_IDENT;
            MODE_DEC:   t = TOK_DEC;
            default:    t = TOK_HEX;
        endcase
        return t;
    endfunction

    // first character of a keyword
    function automatic ext_t pfx_first(logic [7:0] x);
        ext_t e;
        e = '{kind: EXT_NONE, tok: TOK_NEWLINE, pfx: P_DOT};
        unique case (x)
            CH_DOT:  e = mk_pfx(P_DOT);
            "w":     e = mk_pfx(P_W);
            "r":     e = mk_pfx(P_R);
            "j":     e = mk_pfx(P_J);
            "c":     e = mk_pfx(P_C);
            default: e.kind = EXT_NONE;
        endcase
        return e;
    endfunction

    // extend a pending prefix by one character
    function automatic ext_t pfx_ext(pfx_t p, logic [7:0] x);
        ext_t e;
        e = '{kind: EXT_NONE, tok: TOK_NEWLINE, pfx: P_DOT};
        unique case (p)
            P_DOT: begin
                if (x == "d") e = mk_pfx(P_DOT_D);
                else if (x == "c") e = mk_pfx(P_DOT_C);
            end
            P_DOT_D:   if (x == "a") e = mk_pfx(P_DOT_DA);
            P_DOT_DA:  if (x == "t") e = mk_pfx(P_DOT_DAT);
            P_DOT_DAT: if (x == "a") e = mk_kw(TOK_DATA);
            P_DOT_C:   if (x == "o") e = mk_pfx(P_DOT_CO);
            P_DOT_CO:  if (x == "d") e = mk_pfx(P_DOT_COD);
            P_DOT_COD: if (x == "e") e = mk_kw(TOK_CODE);
            P_W:       if (x == "r") e = mk_pfx(P_WR);
            P_WR:      if (x == "i") e = mk_pfx(P_WRI);
            P_WRI:     if (x == "t") e = mk_pfx(P_WRIT);
            P_WRIT:    if (x == "e") e = mk_kw(TOK_WRITE);
            P_R:       if (x == "e") e = mk_pfx(P_RE);
            P_RE: begin
                if (x == "a") e = mk_pfx(P_REA);
                else if (x == "t") e = mk_kw(TOK_RET);
            end
            P_REA:     if (x == "d") e = mk_kw(TOK_READ);
            P_J:       if (x == "m") e = mk_pfx(P_JM);
            P_JM:      if (x == "p") e = mk_kw(TOK_JMP);
            P_C:       if (x == "a") e = mk_pfx(P_CA);
            P_CA:      if (x == "l") e = mk_pfx(P_CAL);
            P_CAL:     if (x == "l") e = mk_kw(TOK_CALL);
            default:   e.kind = EXT_NONE;
        endcase
        return e;
    endfunction

    function automatic logic pfx_dot(pfx_t p);
        logic d;
        unique case (p) inside
            P_DOT, P_DOT_D, P_DOT_DA, P_DOT_DAT, P_DOT_C, P_DOT_CO, P_DOT_COD: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

    // letters of a prefix after any leading dot
    function automatic logic [2:0] pfx_nlet(pfx_t p);
        logic [2:0] n;
        unique case (p) inside
            P_DOT:                                  n = 3'd0;
            P_DOT_D, P_DOT_C, P_W, P_R, P_J, P_C:   n = 3'd1;
            P_DOT_DA, P_DOT_CO, P_WR, P_RE, P_JM, P_CA: n = 3'd2;
            P_DOT_DAT, P_DOT_COD, P_WRI, P_REA, P_CAL:  n = 3'd3;
            P_WRIT:                                 n = 3'd4;
            default:                                n = 3'd0;
        endcase
        return n;
    endfunction

    // letters packed with the first one in the highest used byte
    function automatic logic [31:0] pfx_letters(pfx_t p);
        logic [31:0] w;
        unique case (p)
            P_DOT_D:   w = 32'("d");
            P_DOT_DA:  w = 32'("da");
            P_DOT_DAT: w = 32'("dat");
            P_DOT_C:   w = 32'("c");
            P_DOT_CO:  w = 32'("co");
            P_DOT_COD: w = 32'("cod");
            P_W:       w = 32'("w");
            P_WR:      w = 32'("wr");
            P_WRI:     w = 32'("wri");
            P_WRIT:    w = 32'("writ");
            P_R:       w = 32'("r");
            P_RE:      w = 32'("re");
            P_REA:     w = 32'("rea");
            P_J:       w = 32'("j");
            P_JM:      w = 32'("jm");
            P_C:       w = 32'("c");
            P_CA:      w = 32'("ca");
            P_CAL:     w = 32'("cal");
            default:   w = 32'h0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pfx_letter(pfx_t p, logic [1:0] j);
        logic [31:0] w;
        logic [1:0]  pos;
        w   = pfx_letters(p);
        pos = 2'(pfx_nlet(p) - 3'd1 - {1'b0, j});
        return w[{pos, 3'b000} +: 8];
    endfunction

    // a character seen with no token pending
    function automatic step_t fresh_step(logic [7:0] x);
        step_t s;
        ext_t  e;
        s = '{valid: 1'b0, word: mk_end(TOK_NEWLINE), mode: MODE_IDLE, pfx: P_DOT};
        e = pfx_first(x);
        if (x == CH_SEMI) begin
            s.valid = 1'b1;
            s.mode  = MODE_COMMENT;
        end else if (x == CH_SPACE) begin
            s.valid = 1'b0;
        end else if (x == CH_LF) begin
            s.valid = 1'b1;
        end else if (x == CH_COLON) begin
            s.valid = 1'b1;
            s.word  = mk_end(TOK_COLON);
        end else if (e.kind == EXT_PFX) begin
            s.mode = MODE_PFX;
            s.pfx  = e.pfx;
        end else if (is_alpha(x)) begin
            s.valid = 1'b1;
            s.word  = mk_char(TOK_IDENT, x);
            s.mode  = MODE_IDENT;
        end else if (x == CH_ZERO) begin
            s.mode = MODE_ZERO;
        end else if (is_digit(x)) begin
            s.valid = 1'b1;
            s.word  = mk_char(TOK_DEC, x);
            s.mode  = MODE_DEC;
        end else begin
            s.valid = 1'b1;
            s.word  = mk_err(x);
            s.mode  = MODE_HALT;
        end
        return s;
    endfunction

endpackage

// ===== hdl/assembly_token_scanner.sv =====
// Assembly token scanner: turns a stream of source characters into tokens.
// Input channel (s_): one character per word in s_tdata; s_tlast set marks
// the end of a line, and then s_tdata is ignored. Output channel (m_): one
// token result per word; m_tlast marks the last result caused by one input
// word. Input words that cause no result (spaces, comment text, keyword
// letters still pending) give nothing on m_.
// The first result of an accepted word is classified into the queue and then
// loaded into the output register before it shows on m_tvalid.
// Throughput: one input word per cycle while each causes at most one result
// and m_tready stays high. A word that causes more than one result (up to six,
// for a failed keyword prefix) holds the output until all have left; the
// result queue between the classifier and the output stage takes QUEUE_DEPTH
// such bursts before s_tready drops.
// Reset: the scan mode goes to idle at start of line, the queue empties and
// m_tvalid drops. An ERROR result halts the scanner until the next reset;
// later input words are taken and dropped.
// Stall: while m_tready is low the current result holds in the output
// register, bursts collect in the queue, and s_tready falls when it is full.
module assembly_token_scanner #(
    parameter int QUEUE_DEPTH = ats_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ats_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] ch
    input  logic                            s_tlast,   // end_of_line
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] token_type, [11:4] content_char, [12] has_char, [13] token_end
    output logic [ats_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast    // last_of_run
);
    import ats_pkg::*;

    burst_t push_burst;
    burst_t head_burst;
    logic   q_push, q_full, q_valid, q_pop;

    // classifier and scan mode
    ats_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .ch          (s_tdata[7:0]),
        .end_of_line (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_burst     (push_burst)
    );

    // burst queue
    ats_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_burst (push_burst),
        .full       (q_full),
        .valid      (q_valid),
        .head       (head_burst),
        .pop        (q_pop)
    );

    // result serializer
    ats_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (head_burst),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/ats_front.sv =====
module ats_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      ch,
    input  logic            end_of_line,
    input  logic            q_full,
    output logic            q_push,
    output ats_pkg::burst_t q_burst
);
    import ats_pkg::*;

    mode_t                mode_reg, mode_next;
    pfx_t                 pfx_reg, pfx_next;
    res_t [MAX_RES-1:0]   words;
    logic [CNT_W-1:0]     count;
    logic                 accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (count != '0);
    assign q_burst  = '{count: count, words: words};

    // classify one word: build its results and the next scan mode
    always_comb begin
        logic [CNT_W-1:0] k;
        mode_t            body_mode;
        logic             do_body;
        logic             cont;
        step_t            fs;
        ext_t             ext;
        k         = '0;
        words     = '0;
        mode_next = mode_reg;
        pfx_next  = pfx_reg;
        body_mode = MODE_IDLE;
        do_body   = 1'b0;
        ext       = pfx_ext(pfx_reg, ch);
        fs        = fresh_step(ch);

        if (end_of_line) begin
            // line end: fail any prefix and close what is pending
            unique case (mode_reg) inside
                MODE_IDENT, MODE_DEC, MODE_HEX: begin
                    words[k] = mk_end(run_type(mode_reg));
                    k = k + CNT_W'(1);
                end
                MODE_ZERO: begin
                    words[k] = mk_char(TOK_DEC, CH_ZERO);
                    k = k + CNT_W'(1);
                    words[k] = mk_end(TOK_DEC);
                    k = k + CNT_W'(1);
                end
                MODE_PFX: begin
                    if (pfx_dot(pfx_reg)) begin
                        words[k] = mk_end(TOK_DOT);
                        k = k + CNT_W'(1);
                    end
                    for (int j = 0; j < MAX_LET; j++) begin
                        if (3'(j) < pfx_nlet(pfx_reg)) begin
                            words[k] = mk_char(TOK_IDENT, pfx_letter(pfx_reg, 2'(j)));
                            k = k + CNT_W'(1);
                        end
                    end
                    if (pfx_nlet(pfx_reg) != 3'd0) begin
                        words[k] = mk_end(TOK_IDENT);
                        k = k + CNT_W'(1);
                    end
                end
                MODE_IDLE, MODE_COMMENT, MODE_HALT: begin
                    do_body = 1'b0;
                end
                default: begin
                    do_body = 1'b0;
                end
            endcase
            if (mode_reg != MODE_HALT) begin
                mode_next = MODE_IDLE;
            end
        end else begin
            unique case (mode_reg) inside
                MODE_IDLE, MODE_IDENT, MODE_DEC, MODE_HEX: begin
                    do_body   = 1'b1;
                    body_mode = mode_reg;
                end
                MODE_ZERO: begin
                    if (ch == CH_X) begin
                        mode_next = MODE_HEX;
                    end else begin
                        words[k] = mk_char(TOK_DEC, CH_ZERO);
                        k = k + CNT_W'(1);
                        do_body   = 1'b1;
                        body_mode = MODE_DEC;
                    end
                end
                MODE_PFX: begin
                    if (ext.kind == EXT_KW) begin
                        words[k] = mk_end(ext.tok);
                        k = k + CNT_W'(1);
                        mode_next = MODE_IDLE;
                    end else if (ext.kind == EXT_PFX) begin
                        pfx_next = ext.pfx;
                    end else if (pfx_reg == P_DOT_C && ch == CH_LOWER_A) begin
                        // ".c" relexes as dot then a fresh "c" prefix, which takes the 'a'
                        words[k] = mk_end(TOK_DOT);
                        k = k + CNT_W'(1);
                        pfx_next = P_CA;
                    end else begin
                        // failed prefix: dot and identifier letters, then relex the char
                        if (pfx_dot(pfx_reg)) begin
                            words[k] = mk_end(TOK_DOT);
                            k = k + CNT_W'(1);
                        end
                        for (int j = 0; j < MAX_LET; j++) begin
                            if (3'(j) < pfx_nlet(pfx_reg)) begin
                                words[k] = mk_char(TOK_IDENT, pfx_letter(pfx_reg, 2'(j)));
                                k = k + CNT_W'(1);
                            end
                        end
                        do_body   = 1'b1;
                        body_mode = (pfx_nlet(pfx_reg) == 3'd0) ? MODE_IDLE : MODE_IDENT;
                    end
                end
                MODE_COMMENT, MODE_HALT: begin
                    do_body = 1'b0;
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        // character against a running token or an idle scanner
        if (do_body) begin
            cont = (body_mode == MODE_IDENT) ? (is_alpha(ch) || is_digit(ch)) : is_numch(ch);
            if (body_mode != MODE_IDLE && cont) begin
                words[k] = mk_char(run_type(body_mode), ch);
                k = k + CNT_W'(1);
                mode_next = body_mode;
            end else begin
                if (body_mode != MODE_IDLE) begin
                    words[k] = mk_end(run_type(body_mode));
                    k = k + CNT_W'(1);
                end
                if (fs.valid) begin
                    words[k] = fs.word;
                    k = k + CNT_W'(1);
                end
                mode_next = fs.mode;
                pfx_next  = fs.pfx;
            end
        end
        count = k;
    end

    // scan mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pfx_reg  <= P_DOT;
        end else if (accept) begin
            mode_reg <= mode_next;
            pfx_reg  <= pfx_next;
        end
    end

endmodule

// ===== hdl/ats_queue.sv =====
module ats_queue #(
    parameter int DEPTH = ats_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ats_pkg::burst_t push_burst,
    output logic            full,
    output logic            valid,
    output ats_pkg::burst_t head,
    input  logic            pop
);
    import ats_pkg::*;

    localparam int               PTR_W    = $clog2(DEPTH);
    localparam int               FILL_W   = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    burst_t              slots [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                do_push, do_pop;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign valid   = (fill_reg != '0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_burst;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + FILL_W'(1);
                2'b01:   fill_reg <= fill_reg - FILL_W'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// ===== hdl/ats_back.sv =====
module ats_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  ats_pkg::burst_t                 q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ats_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import ats_pkg::*;

    res_t              out_word_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              load;
    logic              at_last;

    // step through the head burst one word per cycle while m_tready allows
    assign load    = q_valid && (!out_valid_reg || m_tready);
    assign at_last = ((idx_reg + CNT_W'(1)) == q_head.count);
    assign q_pop   = load && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            idx_reg       <= at_last ? '0 : idx_reg + CNT_W'(1);
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (load) begin
            out_word_reg <= q_head.words[idx_reg];
            out_last_reg <= at_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, out_word_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/ats_checker.sv =====
module ats_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ats_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);
    import ats_pkg::*;

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // only identifiers, numbers and errors carry a character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |->
            m_tdata[3:0] == TOK_IDENT || m_tdata[3:0] == TOK_DEC ||
            m_tdata[3:0] == TOK_HEX || m_tdata[3:0] == TOK_ERROR)
        else $error("character on a token without content");

    // a result that does not close its token is a content character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[13] |-> m_tdata[12] &&
            (m_tdata[3:0] == TOK_IDENT || m_tdata[3:0] == TOK_DEC ||
             m_tdata[3:0] == TOK_HEX))
        else $error("open token word without a character");

    // an error closes its token and its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == TOK_ERROR |-> m_tdata[13] && m_tlast)
        else $error("error word does not end the run");

    // nothing follows an error until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[3:0] == TOK_ERROR |=> !m_tvalid)
        else $error("result after an error");

endmodule

bind assembly_token_scanner ats_checker u_ats_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== sim/testbench.sv =====
module testbench;

    import ats_pkg::*;

    // scan state of the predictor
    typedef enum {
        SC_IDLE, SC_COMMENT, SC_IDENT, SC_DEC, SC_HEX, SC_ZERO, SC_HALT, SC_PREFIX
    } scan_t;

    // one token result as it should leave the block
    typedef struct {
        tok_t       kind;
        logic [7:0] text;
        bit         carries;
        bit         closes;
        bit         run_end;
    } token_word_t;

    class token_scoreboard;
        scan_t       mode = SC_IDLE;
        string       held = "";
        token_word_t burst[$];
        token_word_t pending_q[$];
        int          fails = 0;
        int          words_in = 0;
        int          results = 0;

        string kw_text[7] = '{".data", ".code", "write", "read", "ret", "jmp", "call"};
        tok_t  kw_tok[7]  = '{TOK_DATA, TOK_CODE, TOK_WRITE, TOK_READ, TOK_RET, TOK_JMP,
                              TOK_CALL};
        string pfx_text[19] = '{".", ".d", ".da", ".dat", ".c", ".co", ".cod",
                                "w", "wr", "wri", "writ", "r", "re", "rea",
                                "j", "jm", "c", "ca", "cal"};

        function bit is_letter(logic [7:0] x);
            return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == CH_UNDER;
        endfunction

        function bit is_decimal(logic [7:0] x);
            return x >= "0" && x <= "9";
        endfunction

        function bit is_number_char(logic [7:0] x);
            return is_decimal(x) || (x >= "A" && x <= "F");
        endfunction

        // a word carries at most six results
        function void push(tok_t k, logic [7:0] c, bit has, bit fin);
            token_word_t w;
            w = '{kind: k, text: c, carries: has, closes: fin, run_end: 1'b0};
            if (burst.size() < MAX_RES) burst.insert(burst.size(), w);
        endfunction

        // try to lengthen a keyword prefix; a full keyword is emitted at once
        function bit grow_prefix(string p, logic [7:0] x);
            string q;
            if (x == 8'h00) return 1'b0;
            q = {p, " "};
            q.putc(p.len(), x);
            foreach (kw_text[i]) begin
                if (q == kw_text[i]) begin
                    push(kw_tok[i], 8'h00, 1'b0, 1'b1);
                    mode = SC_IDLE;
                    held = "";
                    return 1'b1;
                end
            end
            foreach (pfx_text[i]) begin
                if (q == pfx_text[i]) begin
                    mode = SC_PREFIX;
                    held = q;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // character with nothing pending
        function void start_fresh(logic [7:0] x);
            if (x == CH_SEMI) begin
                push(TOK_NEWLINE, 8'h00, 1'b0, 1'b1);
                mode = SC_COMMENT;
            end else if (x == CH_SPACE) begin
            end else if (x == CH_LF) begin
                push(TOK_NEWLINE, 8'h00, 1'b0, 1'b1);
            end else if (x == CH_COLON) begin
                push(TOK_COLON, 8'h00, 1'b0, 1'b1);
            end else if (grow_prefix("", x)) begin
            end else if (is_letter(x)) begin
                push(TOK_IDENT, x, 1'b1, 1'b0);
                mode = SC_IDENT;
            end else if (x == CH_ZERO) begin
                mode = SC_ZERO;
            end else if (is_decimal(x)) begin
                push(TOK_DEC, x, 1'b1, 1'b0);
                mode = SC_DEC;
            end else begin
                push(TOK_ERROR, x, 1'b1, 1'b1);
                mode = SC_HALT;
            end
        endfunction

        // a dead prefix: dot plus its letters again, or identifier letters
        function void relex(string p);
            mode = SC_IDLE;
            if (p.getc(0) == CH_DOT) begin
                push(TOK_DOT, 8'h00, 1'b0, 1'b1);
                for (int i = 1; i < p.len(); i++) step(p.getc(i));
            end else begin
                for (int i = 0; i < p.len(); i++) push(TOK_IDENT, p.getc(i), 1'b1, 1'b0);
                mode = SC_IDENT;
            end
        endfunction

        function void step(logic [7:0] x);
            tok_t  k;
            string p;
            case (mode) inside
                SC_HALT, SC_COMMENT: begin
                end
                SC_IDLE: start_fresh(x);
                SC_IDENT: begin
                    if (is_letter(x) || is_decimal(x)) begin
                        push(TOK_IDENT, x, 1'b1, 1'b0);
                    end else begin
                        push(TOK_IDENT, 8'h00, 1'b0, 1'b1);
                        mode = SC_IDLE;
                        start_fresh(x);
                    end
                end
                SC_DEC, SC_HEX: begin
                    k = (mode == SC_DEC) ? TOK_DEC : TOK_HEX;
                    if (is_number_char(x)) begin
                        push(k, x, 1'b1, 1'b0);
                    end else begin
                        push(k, 8'h00, 1'b0, 1'b1);
                        mode = SC_IDLE;
                        start_fresh(x);
                    end
                end
                SC_ZERO: begin
                    if (x == CH_X) begin
                        mode = SC_HEX;
                    end else begin
                        push(TOK_DEC, CH_ZERO, 1'b1, 1'b0);
                        mode = SC_DEC;
                        step(x);
                    end
                end
                default: begin
                    p = held;
                    if (!grow_prefix(p, x)) begin
                        relex(p);
                        step(x);
                    end
                end
            endcase
        endfunction

        // end of line closes whatever is open
        function void end_line();
            while (1) begin
                if (mode == SC_IDENT) begin
                    push(TOK_IDENT, 8'h00, 1'b0, 1'b1);
                end else if (mode == SC_DEC) begin
                    push(TOK_DEC, 8'h00, 1'b0, 1'b1);
                end else if (mode == SC_HEX) begin
                    push(TOK_HEX, 8'h00, 1'b0, 1'b1);
                end else if (mode == SC_ZERO) begin
                    push(TOK_DEC, CH_ZERO, 1'b1, 1'b0);
                    push(TOK_DEC, 8'h00, 1'b0, 1'b1);
                end else if (mode == SC_PREFIX) begin
                    relex(held);
                    continue;
                end
                break;
            end
            if (mode != SC_HALT) mode = SC_IDLE;
        endfunction

        // accepted input word
        function void note_input(logic [7:0] ch, logic eol);
            burst.delete();
            if (eol) end_line();
            else step(ch);
            if (burst.size() > 0) burst[burst.size()-1].run_end = 1'b1;
            foreach (burst[i]) pending_q.insert(pending_q.size(), burst[i]);
            words_in++;
        endfunction

        // accepted result word against the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast);
            token_word_t w;
            results++;
            if (pending_q.size() == 0) begin
                $error("result with none expected: tdata %h tlast %b", tdata, tlast);
                fails++;
                return;
            end
            w = pending_q.pop_front();
            if (tdata[3:0] !== w.kind) begin
                $error("token_type: expected %0d, got %0d", w.kind, tdata[3:0]);
                fails++;
            end
            if (tdata[11:4] !== w.text) begin
                $error("content_char: expected %h, got %h", w.text, tdata[11:4]);
                fails++;
            end
            if (tdata[12] !== w.carries) begin
                $error("has_char: expected %b, got %b", w.carries, tdata[12]);
                fails++;
            end
            if (tdata[13] !== w.closes) begin
                $error("token_end: expected %b, got %b", w.closes, tdata[13]);
                fails++;
            end
            if (tlast !== w.run_end) begin
                $error("last_of_run: expected %b, got %b", w.run_end, tlast);
                fails++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    token_scoreboard sb;
    bit              calm = 1'b0;
    int              sent = 0;
    int              lines = 0;

    string keywords[7] = '{".data", ".code", "write", "read", "ret", "jmp", "call"};
    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string numchars = "0123456789ABCDEF";
    string legal = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789.:; ";

    assembly_token_scanner i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // watch both channels; inputs are noted before results are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    function automatic logic [7:0] pick(string set);
        return set.getc($urandom_range(0, set.len() - 1));
    endfunction

    function automatic bit in_language(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER
            || (b >= "0" && b <= "9") || b == CH_SEMI || b == CH_COLON || b == CH_DOT
            || b == CH_SPACE || b == CH_LF;
    endfunction

    // one word on the input channel, with an occasional gap before it
    task automatic send_word(logic [7:0] c, logic eol);
        if (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(s.getc(i), 1'b0);
    endtask

    // line end carries a random byte that the block must ignore
    task automatic send_eol();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        lines++;
    endtask

    // one random token-like piece of a source line
    task automatic random_piece();
        string k;
        int    n;
        k = keywords[$urandom_range(0, 6)];
        case ($urandom_range(0, 7))
            0: begin
                send_text(k);
                if ($urandom_range(1)) send_word(pick(letters), 1'b0);
            end
            1: begin
                send_text(k.substr(0, $urandom_range(0, k.len() - 2)));
                if ($urandom_range(3) != 0) send_word(pick(legal), 1'b0);
            end
            2: begin
                send_word(pick(letters), 1'b0);
                n = $urandom_range(0, 5);
                repeat (n) send_word($urandom_range(1) ? pick(letters) : pick(numchars), 1'b0);
            end
            3: begin
                send_word(8'($urandom_range("1", "9")), 1'b0);
                repeat ($urandom_range(0, 4)) send_word(pick(numchars), 1'b0);
            end
            4: begin
                send_text("0x");
                repeat ($urandom_range(0, 4)) send_word(pick(numchars), 1'b0);
            end
            5: begin
                send_word(CH_ZERO, 1'b0);
                send_word(pick(legal), 1'b0);
            end
            6: begin
                case ($urandom_range(0, 2))
                    0: send_word(CH_COLON, 1'b0);
                    1: send_word(CH_DOT, 1'b0);
                    default: send_word(CH_LF, 1'b0);
                endcase
            end
            default: begin
                repeat ($urandom_range(1, 3)) send_word(pick(legal), 1'b0);
            end
        endcase
        if ($urandom_range(1)) send_word(CH_SPACE, 1'b0);
    endtask

    initial begin
        logic [7:0] bad;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: keyword, dead dot prefix, longest burst, empty hex,
        // lone zero, numbers with hex letters, comment, bare LF and space
        send_text(".data.cx");
        send_eol();
        send_text("writ;");
        send_word(8'hFF, 1'b0);
        send_eol();
        send_text("0x");
        send_eol();
        send_text("0:9F");
        send_word(CH_LF, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_ZERO, 1'b0);
        send_eol();

        // random lines of tokens, some with comments of raw bytes
        while (sent < 230) begin
            calm <= (sent >= 120 && sent < 180);
            repeat ($urandom_range(1, 5)) random_piece();
            if ($urandom_range(4) == 0) begin
                send_word(CH_SEMI, 1'b0);
                repeat ($urandom_range(0, 4)) send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            send_eol();
        end

        // a byte outside the language halts the scanner; later words are dropped
        do bad = 8'($urandom_range(0, 255)); while (in_language(bad));
        send_word("r", 1'b0);
        send_word(bad, 1'b0);
        send_text("ab1");
        send_eol();
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d input words over %0d lines, ending in a halting error", sb.words_in,
                 lines);
        $display("%0d token results checked, %0d mismatches", sb.results, sb.fails);
        if (sb.fails == 0) begin
            $display("assembly_token_scanner regression: pass");
        end else begin
            $display("assembly_token_scanner regression: fail");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #3000000;
        $display("assembly_token_scanner regression: fail");
        $finish;
    end

endmodule
